/* hdl/sv39ptm_pkg.sv */
// sv39ptm_pkg: constants, codes and payload types of the sv39 page table mapper
// used by sv39_page_table_mapper; no dependencies
package sv39ptm_pkg;

  localparam int unsigned TABLE_PAGES      = 64;
  localparam int unsigned ENTRIES_PER_PAGE = 512;

  localparam int unsigned PAGE_W     = $clog2(TABLE_PAGES);
  localparam int unsigned VPN_W      = $clog2(ENTRIES_PER_PAGE);
  localparam int unsigned STORE_AW   = PAGE_W + VPN_W;
  localparam int unsigned STORE_DEPTH = TABLE_PAGES * ENTRIES_PER_PAGE;
  localparam int unsigned NFP_W      = $clog2(TABLE_PAGES + 1);

  localparam int unsigned PTE_W      = 64;
  localparam int unsigned PPN_W      = 44;
  localparam int unsigned PTE_LOW_W  = 10;
  localparam int unsigned VA_W       = 39;
  localparam int unsigned PA_W       = 56;
  localparam int unsigned SIZE_W     = 40;
  localparam int unsigned PERM_W     = 8;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned CNT_W      = SIZE_W - PAGE_SHIFT + 1;
  localparam int unsigned MAPPED_W   = 28;
  localparam int unsigned USED_W     = 7;

  localparam int unsigned VPN2_LSB = 30;
  localparam int unsigned VPN1_LSB = 21;
  localparam int unsigned VPN0_LSB = 12;

  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_IDX_LSB = 3;

  localparam logic [CFG_ADDR_W-CFG_IDX_LSB-1:0] REG_TABLE_BASE = '0;

  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_EXHAUSTED = 2'd1,
    STATUS_OUTSIDE   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_L2_RD,
    FSM_L2_CHK,
    FSM_L1_CHK,
    FSM_LEAF
  } fsm_e;

  typedef struct packed {
    logic [VA_W-1:0]   virt_addr;
    logic [PA_W-1:0]   phys_addr;
    logic [SIZE_W-1:0] size_bytes;
    logic [PERM_W-1:0] perm;
  } map_req_t;

  typedef struct packed {
    status_e             status;
    logic [MAPPED_W-1:0] pages_mapped;
    logic [USED_W-1:0]   tables_used;
  } map_rsp_t;

endpackage

/* hdl/sv39ptm_ram.sv */
// sv39ptm_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module sv39ptm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/sv39_page_table_mapper.sv */
// sv39_page_table_mapper: builds sv39 page tables in an on-chip table store
// depends on sv39ptm_pkg and sv39ptm_ram
// each page walk: read of the root entry, pointer/allocate check at each level,
// leaf write (one memory port); an empty region finishes without a walk
// throughput: one region at a time, busy high until its result strobe
// reset: clearing pass over all 32768 entries of the table store with busy high; the result
// strobe cannot be stalled by the receiver
module sv39_page_table_mapper
  import sv39ptm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  map_req_t              item_i,
  output logic                  done_o,
  output map_rsp_t              result_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  fsm_e                state_q, state_d;
  logic [STORE_AW-1:0] clr_q, clr_d;
  logic [NFP_W-1:0]    nfp_q, nfp_d;
  logic [PPN_W-1:0]    base_q;
  logic [VA_W-1:0]     va_q, va_d;
  logic [PA_W-1:0]     pa_q, pa_d;
  logic [PERM_W-1:0]   perm_q, perm_d;
  logic [CNT_W-1:0]    pages_q, pages_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [PAGE_W-1:0]   mid_q, mid_d;
  logic [PAGE_W-1:0]   leaf_q, leaf_d;
  logic                done_q, done_d;
  map_rsp_t            res_q, res_d;

  logic                ram_we, ram_re;
  logic [STORE_AW-1:0] ram_waddr, ram_raddr;
  logic [PTE_W-1:0]    ram_wdata, ram_rdata;

  logic [VPN_W-1:0]    vpn2, vpn1, vpn0;
  logic [PPN_W-1:0]    ent_rel;
  logic                ent_valid, rel_ok, alloc_full;
  logic [PAGE_W-1:0]   next_page;
  logic [PTE_W-1:0]    ptr_pte, leaf_pte;
  logic [SIZE_W:0]     size_round;
  logic                cfg_wr;

  sv39ptm_ram #(
    .WIDTH(PTE_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[CFG_ADDR_W-1:CFG_IDX_LSB] == REG_TABLE_BASE);
  assign prdata = (paddr[CFG_ADDR_W-1:CFG_IDX_LSB] == REG_TABLE_BASE) ?
                  CFG_DATA_W'(base_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_wr) begin
      base_q <= pwdata[PPN_W-1:0];
    end
  end

  assign vpn2 = va_q[VPN2_LSB +: VPN_W];
  assign vpn1 = va_q[VPN1_LSB +: VPN_W];
  assign vpn0 = va_q[VPN0_LSB +: VPN_W];

  // entry check shared by both walk levels
  assign ent_valid  = ram_rdata[0];
  assign ent_rel    = ram_rdata[PTE_LOW_W +: PPN_W] - base_q;
  assign rel_ok     = (ent_rel < PPN_W'(TABLE_PAGES));
  assign alloc_full = (nfp_q >= NFP_W'(TABLE_PAGES));
  assign next_page  = ent_valid ? ent_rel[PAGE_W-1:0] : nfp_q[PAGE_W-1:0];
  assign ptr_pte    = {(PTE_W - PPN_W - PTE_LOW_W)'(0), base_q + PPN_W'(nfp_q),
                       PTE_LOW_W'(1)};
  assign leaf_pte   = {(PTE_W - PPN_W - PTE_LOW_W)'(0), pa_q[PAGE_SHIFT +: PPN_W],
                       (PTE_LOW_W - PERM_W)'(0), perm_q[PERM_W-1:1], 1'b1};
  assign size_round = {1'b0, item_i.size_bytes} + (SIZE_W+1)'((1 << PAGE_SHIFT) - 1);

  assign busy = (state_q != FSM_IDLE);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    nfp_d     = nfp_q;
    va_d      = va_q;
    pa_d      = pa_q;
    perm_d    = perm_q;
    pages_d   = pages_q;
    cnt_d     = cnt_q;
    mid_d     = mid_q;
    leaf_d    = leaf_q;
    done_d    = 1'b0;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = ptr_pte;
    ram_re    = 1'b0;
    ram_raddr = '0;

    unique case (state_q)
      FSM_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + STORE_AW'(1);
        if (clr_q == STORE_AW'(STORE_DEPTH - 1)) begin
          state_d = FSM_IDLE;
        end
      end
      FSM_IDLE: begin
        if (start) begin
          va_d    = item_i.virt_addr;
          pa_d    = item_i.phys_addr;
          perm_d  = item_i.perm;
          pages_d = size_round[SIZE_W:PAGE_SHIFT];
          cnt_d   = '0;
          state_d = FSM_L2_RD;
        end
      end
      FSM_L2_RD: begin
        if (cnt_q == pages_q) begin
          done_d  = 1'b1;
          res_d   = '{STATUS_DONE, cnt_q[MAPPED_W-1:0], USED_W'(nfp_q)};
          state_d = FSM_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = {PAGE_W'(0), vpn2};
          state_d   = FSM_L2_CHK;
        end
      end
      FSM_L2_CHK, FSM_L1_CHK: begin
        if (!ent_valid && alloc_full) begin
          done_d  = 1'b1;
          res_d   = '{STATUS_EXHAUSTED, cnt_q[MAPPED_W-1:0], USED_W'(nfp_q)};
          state_d = FSM_IDLE;
        end else if (ent_valid && !rel_ok) begin
          done_d  = 1'b1;
          res_d   = '{STATUS_OUTSIDE, cnt_q[MAPPED_W-1:0], USED_W'(nfp_q)};
          state_d = FSM_IDLE;
        end else begin
          if (!ent_valid) begin
            ram_we = 1'b1;
            nfp_d  = nfp_q + NFP_W'(1);
          end
          if (state_q == FSM_L2_CHK) begin
            ram_waddr = {PAGE_W'(0), vpn2};
            ram_re    = 1'b1;
            ram_raddr = {next_page, vpn1};
            mid_d     = next_page;
            state_d   = FSM_L1_CHK;
          end else begin
            ram_waddr = {mid_q, vpn1};
            leaf_d    = next_page;
            state_d   = FSM_LEAF;
          end
        end
      end
      FSM_LEAF: begin
        ram_we    = 1'b1;
        ram_waddr = {leaf_q, vpn0};
        ram_wdata = leaf_pte;
        cnt_d     = cnt_q + CNT_W'(1);
        va_d      = {va_q[VA_W-1:PAGE_SHIFT] + (VA_W-PAGE_SHIFT)'(1), va_q[PAGE_SHIFT-1:0]};
        pa_d      = {pa_q[PA_W-1:PAGE_SHIFT] + (PA_W-PAGE_SHIFT)'(1), pa_q[PAGE_SHIFT-1:0]};
        state_d   = FSM_L2_RD;
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_CLEAR;
      clr_q   <= '0;
      nfp_q   <= NFP_W'(1);
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      nfp_q   <= nfp_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    va_q    <= va_d;
    pa_q    <= pa_d;
    perm_q  <= perm_d;
    pages_q <= pages_d;
    cnt_q   <= cnt_d;
    mid_q   <= mid_d;
    leaf_q  <= leaf_d;
    res_q   <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // a read never meets a write to the same entry in one cycle
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("table store read and write hit the same entry");

  a_nfp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nfp_q >= NFP_W'(1)) && (nfp_q <= NFP_W'(TABLE_PAGES)))
    else $error("allocator count out of range");

  a_l1_follows_l2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_L1_CHK) |-> $past(state_q == FSM_L2_CHK))
    else $error("level one check without level two check");

  a_used_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.tables_used == USED_W'(nfp_q)))
    else $error("reported table count differs from allocator");

  a_leaf_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_LEAF) |-> $past(state_q == FSM_L1_CHK))
    else $error("leaf write without completed walk");

endmodule
